// ===== design/vdr_pkg.sv =====
// ----------------------------------------------------------------------------
// vdr_pkg
// Shared constants and the CORDIC arctangent table for the planar
// dead-reckoning integrator.
// ----------------------------------------------------------------------------
package vdr_pkg;

    // Number of CORDIC micro-rotations, 12 to 32.
    localparam int CORDIC_STAGES = 24;
    // Width of the saturated time step, 16 to 32.
    localparam int DT_BITS = 24;

    // Field widths.
    localparam int STAMP_W = 48;
    localparam int VEL_W   = 24;
    localparam int RATE_W  = 25;
    localparam int POS_W   = 48;
    localparam int ANG_W   = 32;
    localparam int QUAT_W  = 32;

    // Shared multiplier operand width: holds dx, dy and the split heading step.
    localparam int MUL_W  = (DT_BITS + 5 > 33) ? DT_BITS + 5 : 33;
    localparam int PROD_W = 2 * MUL_W;
    // Width of the recombined heading step before the final shift.
    localparam int TURN_W = PROD_W + 16;
    // Position sum with headroom for two rotation products.
    localparam int SUM_W  = POS_W + 3;
    // CORDIC datapath width.
    localparam int CRD_W  = 34;
    // Iteration counter width.
    localparam int CNT_W  = $clog2(CORDIC_STAGES);

    localparam logic signed [MUL_W-1:0] INV_PI_Q30  = MUL_W'(341782638);
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = CRD_W'(652032874);
    localparam logic signed [CRD_W-1:0] ONE_Q30     = CRD_W'(1073741824);

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

    // Arctangent of 2^-i as a binary angle of full scale 2 pi.
    function automatic logic [31:0] atan_val(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051D;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2E;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2F9;
            5'd15:   v = 32'h0000_517C;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A2F;
            5'd19:   v = 32'h0000_0517;
            5'd20:   v = 32'h0000_028B;
            5'd21:   v = 32'h0000_0145;
            5'd22:   v = 32'h0000_00A2;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0028;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0002;
            5'd29:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== design/velocity_dead_reckoning_integrator.sv =====
// ----------------------------------------------------------------------------
// velocity_dead_reckoning_integrator
// Integrates timestamped body velocities into a planar pose with one shared
// multiplier and one shared CORDIC rotator under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one velocity sample per transaction (stamp,
// vel_fwd, vel_side, yaw_rate). A transaction completes when in_valid is high
// and in_stall is low. The output channel carries one pose per accepted
// sample (out_stamp, pos_x, pos_y, heading, quat_z, quat_w) with the same
// valid and stall handshake.
// A sample whose stamp is older than the last accepted one is dropped in the
// cycle after acceptance and produces no result. Otherwise the result follows
// the time step, the multiplier steps, a CORDIC pass for the rotation, the
// position update and a CORDIC pass for the quaternion, one iteration a cycle.
// One sample is in flight at a time, so in_stall stays high from acceptance
// until the result transaction completes. If the receiver stalls, the result
// holds and in_stall stays high. Reset clears the pose, heading, held
// velocities and last stamp. The first sample after reset has a zero time
// step: it latches its stamp and velocities, leaves the pose as it is and
// still produces a result.
// ----------------------------------------------------------------------------
module velocity_dead_reckoning_integrator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [vdr_pkg::STAMP_W-1:0]          stamp,
    input  logic signed [vdr_pkg::VEL_W-1:0]     vel_fwd,
    input  logic signed [vdr_pkg::VEL_W-1:0]     vel_side,
    input  logic signed [vdr_pkg::RATE_W-1:0]    yaw_rate,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vdr_pkg::STAMP_W-1:0]          out_stamp,
    output logic signed [vdr_pkg::POS_W-1:0]     pos_x,
    output logic signed [vdr_pkg::POS_W-1:0]     pos_y,
    output logic [vdr_pkg::ANG_W-1:0]            heading,
    output logic signed [vdr_pkg::QUAT_W-1:0]    quat_z,
    output logic signed [vdr_pkg::QUAT_W-1:0]    quat_w
);
    import vdr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DT, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
        S_CI, S_CR, S_CP, S_R1, S_R2, S_R3, S_R4, S_R5, S_POS, S_OUT
    } state_t;

    state_t                     state_reg;
    logic                       started_reg;
    logic                       qmode_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic [STAMP_W-1:0]         in_stamp_reg;
    logic signed [VEL_W-1:0]    in_vf_reg;
    logic signed [VEL_W-1:0]    in_vs_reg;
    logic signed [RATE_W-1:0]   in_wr_reg;

    logic signed [SUM_W-1:0]    acc_x_reg;
    logic signed [SUM_W-1:0]    acc_y_reg;
    logic [ANG_W-1:0]           acc_heading_reg;
    logic signed [VEL_W-1:0]    held_vf_reg;
    logic signed [VEL_W-1:0]    held_vs_reg;
    logic [STAMP_W-1:0]         last_stamp_reg;

    logic [DT_BITS:0]           dt_reg;
    logic signed [MUL_W-1:0]    dx_reg;
    logic signed [MUL_W-1:0]    dy_reg;
    logic [14:0]                al_reg;
    logic signed [PROD_W-1:0]   p1_reg;
    logic signed [MUL_W-1:0]    sn_reg;
    logic signed [MUL_W-1:0]    cs_reg;
    logic signed [SUM_W-1:0]    sx_reg;
    logic signed [SUM_W-1:0]    sy_reg;

    logic signed [CRD_W-1:0]    cx_reg;
    logic signed [CRD_W-1:0]    cy_reg;
    logic signed [CRD_W-1:0]    cz_reg;
    logic                       flip_reg;

    logic [QUAT_W-1:0]          qz_reg;
    logic [QUAT_W-1:0]          qw_reg;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod_reg;

    // Time step, drop test and saturation.
    logic [STAMP_W-1:0]         base_stamp;
    logic [STAMP_W-1:0]         diff;
    logic                       drop;
    logic [DT_BITS:0]           dt_next;

    always_comb
    begin
        base_stamp = started_reg ? last_stamp_reg : in_stamp_reg;
        drop       = in_stamp_reg < base_stamp;
        diff       = in_stamp_reg - base_stamp;
        if (diff > STAMP_W'({1'b1, {DT_BITS{1'b0}}}))
            dt_next = {1'b1, {DT_BITS{1'b0}}};
        else
            dt_next = diff[DT_BITS:0];
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M1:
            begin
                mul_a = MUL_W'(held_vf_reg);
                mul_b = MUL_W'($signed({1'b0, dt_reg}));
            end
            S_M2:
            begin
                mul_a = MUL_W'(held_vs_reg);
                mul_b = MUL_W'($signed({1'b0, dt_reg}));
            end
            S_M3:
            begin
                mul_a = MUL_W'(in_wr_reg);
                mul_b = MUL_W'($signed({1'b0, dt_reg}));
            end
            S_M4:
            begin
                mul_a = MUL_W'(prod_reg >>> 25);
                mul_b = INV_PI_Q30;
            end
            S_M5:
            begin
                mul_a = MUL_W'($signed({1'b0, al_reg}));
                mul_b = INV_PI_Q30;
            end
            S_R1:
            begin
                mul_a = dx_reg;
                mul_b = sn_reg;
            end
            S_R2:
            begin
                mul_a = dy_reg;
                mul_b = cs_reg;
            end
            S_R3:
            begin
                mul_a = dx_reg;
                mul_b = cs_reg;
            end
            S_R4:
            begin
                mul_a = dy_reg;
                mul_b = sn_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Registered product of the shared multiplier.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Heading step recombined from the two partial products.
    logic signed [TURN_W-1:0]   turn_sum;
    logic signed [SUM_W-1:0]    rot_term;

    always_comb
    begin
        turn_sum = (TURN_W'(p1_reg) <<< 15) + TURN_W'(prod_reg);
        rot_term = SUM_W'(prod_reg >>> 30);
    end

    // CORDIC start angle, one iteration and the final clamp.
    logic [ANG_W-1:0]           cord_ang;
    logic                       cord_flip;
    logic signed [CRD_W-1:0]    cx_sh;
    logic signed [CRD_W-1:0]    cy_sh;
    logic signed [CRD_W-1:0]    atan_step;
    logic signed [CRD_W-1:0]    cx_clamp;
    logic signed [CRD_W-1:0]    cy_clamp;
    logic signed [CRD_W-1:0]    sin_val;
    logic signed [CRD_W-1:0]    cos_val;

    always_comb
    begin
        cord_ang  = qmode_reg ? acc_heading_reg : {acc_heading_reg[ANG_W-2:0], 1'b0};
        cord_flip = (cord_ang[31:30] == 2'b01) || (cord_ang[31:30] == 2'b10);
        cx_sh     = cx_reg >>> cnt_reg;
        cy_sh     = cy_reg >>> cnt_reg;
        atan_step = CRD_W'(atan_val(5'(cnt_reg)));
        if (cx_reg > ONE_Q30)
            cx_clamp = ONE_Q30;
        else if (cx_reg < -ONE_Q30)
            cx_clamp = -ONE_Q30;
        else
            cx_clamp = cx_reg;
        if (cy_reg > ONE_Q30)
            cy_clamp = ONE_Q30;
        else if (cy_reg < -ONE_Q30)
            cy_clamp = -ONE_Q30;
        else
            cy_clamp = cy_reg;
        sin_val = flip_reg ? -cy_clamp : cy_clamp;
        cos_val = flip_reg ? -cx_clamp : cx_clamp;
    end

    // Position saturation.
    logic signed [SUM_W-1:0]    sat_x;
    logic signed [SUM_W-1:0]    sat_y;

    always_comb
    begin
        if (sx_reg > POS_MAX)
            sat_x = POS_MAX;
        else if (sx_reg < POS_MIN)
            sat_x = POS_MIN;
        else
            sat_x = sx_reg;
        if (sy_reg > POS_MAX)
            sat_y = POS_MAX;
        else if (sy_reg < POS_MIN)
            sat_y = POS_MIN;
        else
            sat_y = sy_reg;
    end

    // Sequencer with its state and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            started_reg     <= 1'b0;
            qmode_reg       <= 1'b0;
            cnt_reg         <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            held_vf_reg     <= '0;
            held_vs_reg     <= '0;
            last_stamp_reg  <= '0;
            in_stamp_reg    <= '0;
            in_vf_reg       <= '0;
            in_vs_reg       <= '0;
            in_wr_reg       <= '0;
            dt_reg          <= '0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            al_reg          <= '0;
            p1_reg          <= '0;
            sn_reg          <= '0;
            cs_reg          <= '0;
            sx_reg          <= '0;
            sy_reg          <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            cz_reg          <= '0;
            flip_reg        <= 1'b0;
            qz_reg          <= '0;
            qw_reg          <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_stamp_reg <= stamp;
                        in_vf_reg    <= vel_fwd;
                        in_vs_reg    <= vel_side;
                        in_wr_reg    <= yaw_rate;
                        state_reg    <= S_DT;
                    end
                end
                S_DT:
                begin
                    dt_reg    <= dt_next;
                    state_reg <= drop ? S_IDLE : S_M1;
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    dx_reg    <= MUL_W'(prod_reg >>> 20);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    dy_reg    <= MUL_W'(prod_reg >>> 20);
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    al_reg    <= prod_reg[24:10];
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    p1_reg    <= prod_reg;
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    acc_heading_reg <= acc_heading_reg - turn_sum[61:30];
                    qmode_reg       <= 1'b0;
                    state_reg       <= S_CI;
                end
                S_CI:
                begin
                    cx_reg    <= CORDIC_GAIN;
                    cy_reg    <= '0;
                    cz_reg    <= CRD_W'($signed({~cord_ang[31] ^ ~cord_flip,
                                                 cord_ang[30:0]}));
                    flip_reg  <= cord_flip;
                    cnt_reg   <= '0;
                    state_reg <= S_CR;
                end
                S_CR:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - cy_sh;
                        cy_reg <= cy_reg + cx_sh;
                        cz_reg <= cz_reg - atan_step;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + cy_sh;
                        cy_reg <= cy_reg - cx_sh;
                        cz_reg <= cz_reg + atan_step;
                    end
                    if (cnt_reg == CNT_W'(CORDIC_STAGES - 1))
                        state_reg <= S_CP;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_CP:
                begin
                    if (qmode_reg)
                    begin
                        qz_reg    <= QUAT_W'(sin_val);
                        qw_reg    <= QUAT_W'(cos_val);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        sn_reg    <= MUL_W'(sin_val);
                        cs_reg    <= MUL_W'(cos_val);
                        state_reg <= S_R1;
                    end
                end
                S_R1:
                begin
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    sx_reg    <= acc_x_reg + rot_term;
                    state_reg <= S_R3;
                end
                S_R3:
                begin
                    sx_reg    <= sx_reg + rot_term;
                    state_reg <= S_R4;
                end
                S_R4:
                begin
                    sy_reg    <= acc_y_reg + rot_term;
                    state_reg <= S_R5;
                end
                S_R5:
                begin
                    sy_reg    <= sy_reg - rot_term;
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    acc_x_reg      <= sat_x;
                    acc_y_reg      <= sat_y;
                    held_vf_reg    <= in_vf_reg;
                    held_vs_reg    <= in_vs_reg;
                    last_stamp_reg <= in_stamp_reg;
                    started_reg    <= 1'b1;
                    qmode_reg      <= 1'b1;
                    state_reg      <= S_CI;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Ports.
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_stamp = last_stamp_reg;
    assign pos_x     = POS_W'(acc_x_reg);
    assign pos_y     = POS_W'(acc_y_reg);
    assign heading   = acc_heading_reg;
    assign quat_z    = qz_reg;
    assign quat_w    = qw_reg;

    // The block never takes a new sample while a result waits.
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("sample accepted while result pending");

    // The time step never exceeds its saturation limit.
    a_dt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M1) |-> (dt_reg <= {1'b1, {DT_BITS{1'b0}}}))
        else $error("time step above saturation limit");

    // Quaternion components stay within plus or minus one.
    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((quat_z <= 32'sd1073741824) && (quat_z >= -32'sd1073741824)
                    && (quat_w <= 32'sd1073741824) && (quat_w >= -32'sd1073741824)))
        else $error("quaternion component out of range");

    // A dropped sample leaves the pose untouched.
    a_drop_keeps_pose: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DT && drop) |=> ($stable(acc_x_reg) && $stable(acc_y_reg)
                                          && $stable(acc_heading_reg)))
        else $error("dropped sample changed pose");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the planar dead-reckoning integrator. It drives
// velocity samples from a directed table and then from a random stream of
// rising stamps with some stale ones mixed in. A fixed-point model of the
// pose update, including its own CORDIC rotator, predicts every pose. Each
// completed output transaction is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vdr_pkg::*;

    localparam int  N_RANDOM   = 1280;
    localparam int  HOLD_LEN   = 400;
    localparam int  DRAIN_WAIT = 100;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [STAMP_W-1:0]        stamp;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic [ANG_W-1:0]          hd;
        logic signed [QUAT_W-1:0]  qz;
        logic signed [QUAT_W-1:0]  qw;
    } pose_t;

    typedef struct {
        logic [STAMP_W-1:0]        stamp;
        logic signed [VEL_W-1:0]   vf;
        logic signed [VEL_W-1:0]   vs;
        logic signed [RATE_W-1:0]  wr;
        bit                        known;
        logic signed [POS_W-1:0]   kx;
        logic signed [POS_W-1:0]   ky;
        logic [ANG_W-1:0]          khd;
    } sample_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [STAMP_W-1:0] stamp;
    logic signed [VEL_W-1:0] vel_fwd;
    logic signed [VEL_W-1:0] vel_side;
    logic signed [RATE_W-1:0] yaw_rate;
    logic out_valid;
    logic out_stall;
    logic [STAMP_W-1:0] out_stamp;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANG_W-1:0] heading;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;

    // Pose model state.
    longint pose_x, pose_y;
    logic [31:0] pose_hd;
    longint held_fwd, held_side;
    logic [STAMP_W-1:0] prev_stamp;
    bit seen_first;

    pose_t pending_poses[$];
    sample_row_t stim_table[$];
    int mismatches;
    longint cycles = 0;
    bit quiet;
    bit hold_req;

    logic [31:0] arctan_tab [0:31] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
        32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001,
        32'h0000_0000, 32'h0000_0000};

    velocity_dead_reckoning_integrator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .stamp(stamp), .vel_fwd(vel_fwd), .vel_side(vel_side), .yaw_rate(yaw_rate),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_stamp(out_stamp), .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .quat_z(quat_z), .quat_w(quat_w)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // floor(a*b / 2^30) without overflowing 64 bits.
    function automatic longint mul_q30(longint a, longint b);
        longint ah, al, p, ph, pl;
        ah = a >>> 15;
        al = a - ah * 32768;
        p  = ah * b;
        ph = p >>> 15;
        pl = p - ph * 32768;
        return ph + ((pl * 32768 + al * b) >>> 30);
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    // Sine and cosine of a binary angle of full scale 2 pi.
    task automatic rotate_angle(input logic [31:0] ang, output longint sn, output longint cs);
        logic [31:0] a;
        bit flip;
        longint z, x, y, xs, ys;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        a = flip ? ang + 32'h8000_0000 : ang;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - longint'(arctan_tab[i]);
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + longint'(arctan_tab[i]);
            end
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
        if (flip)
        begin
            x = -x; y = -y;
        end
        sn = y;
        cs = x;
    endtask

    function automatic longint sat_pos(longint v);
        longint hi;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Advances the pose model by one sample; clears emitted for a stale stamp.
    task automatic integrate_sample(input sample_row_t s, output bit emitted,
                                    output pose_t p);
        logic [STAMP_W-1:0] dtu;
        longint dt, dx, dy, turn, sn, cs, qz, qw;
        emitted = 1'b0;
        if (!seen_first)
        begin
            seen_first = 1'b1;
            prev_stamp = s.stamp;
        end
        if (s.stamp < prev_stamp)
            return;
        dtu = s.stamp - prev_stamp;
        if (dtu > (48'd1 << DT_BITS))
            dtu = 48'd1 << DT_BITS;
        dt = longint'(dtu);
        dx = (held_fwd * dt) >>> 20;
        dy = (held_side * dt) >>> 20;
        turn = mul_q30((longint'(s.wr) * dt) >>> 10, 341782638);
        pose_hd = pose_hd - turn[31:0];
        rotate_angle(pose_hd << 1, sn, cs);
        pose_x = sat_pos(pose_x + mul_q30(dx, sn) + mul_q30(dy, cs));
        pose_y = sat_pos(pose_y + mul_q30(dx, cs) - mul_q30(dy, sn));
        held_fwd = longint'(s.vf);
        held_side = longint'(s.vs);
        prev_stamp = s.stamp;
        rotate_angle(pose_hd, qz, qw);
        p.stamp = s.stamp;
        p.x = pose_x[47:0];
        p.y = pose_y[47:0];
        p.hd = pose_hd;
        p.qz = qz[31:0];
        p.qw = qw[31:0];
        emitted = 1'b1;
    endtask

    function automatic void add_row(logic [47:0] st, longint vf, longint vs, longint wr,
                                     bit known = 0);
        sample_row_t r;
        r.stamp = st;
        r.vf = vf[23:0];
        r.vs = vs[23:0];
        r.wr = wr[24:0];
        r.known = known;
        r.kx = '0;
        r.ky = '0;
        r.khd = '0;
        stim_table.push_back(r);
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose transaction, stamp %0d", out_stamp);
            end
            else
            begin
                e = pending_poses.pop_front();
                if (out_stamp !== e.stamp || pos_x !== e.x || pos_y !== e.y ||
                    heading !== e.hd || quat_z !== e.qz || quat_w !== e.qw)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("pose mismatch: expected stamp %0d x %0d y %0d hd %h qz %0d qw %0d",
                                 e.stamp, e.x, e.y, e.hd, e.qz, e.qw);
                        $display("                 actual stamp %0d x %0d y %0d hd %h qz %0d qw %0d",
                                 out_stamp, pos_x, pos_y, heading, quat_z, quat_w);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, quiet stretch without stalls.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 18);
        end
    end

    // Sends one sample and predicts its pose when the block takes it.
    // Returns at a falling edge with in_valid still high.
    task automatic send_sample(input sample_row_t s);
        bit emitted;
        pose_t p;
        if (!quiet && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        stamp <= s.stamp;
        vel_fwd <= s.vf;
        vel_side <= s.vs;
        yaw_rate <= s.wr;
        do
            @(posedge clk);
        while (in_stall);
        integrate_sample(s, emitted, p);
        if (emitted)
        begin
            if (s.known)
            begin
                p.stamp = s.stamp;
                p.x = s.kx;
                p.y = s.ky;
                p.hd = s.khd;
            end
            pending_poses.push_back(p);
        end
        @(negedge clk);
    endtask

    // Stimulus.
    initial
    begin
        sample_row_t r;
        logic [47:0] cur, inc;
        int sent, pick;
        bit ok;

        in_valid = 1'b0;
        stamp = '0;
        vel_fwd = '0;
        vel_side = '0;
        yaw_rate = '0;
        mismatches = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        pose_x = 0; pose_y = 0; pose_hd = '0;
        held_fwd = 0; held_side = 0; prev_stamp = '0; seen_first = 1'b0;

        // Directed samples: first sample, stale stamp, equal stamp, gaps below and
        // beyond the dt limit, and the velocity and rate extremes.
        add_row(48'd1000, 8388607, -8388608, 16777215, 1);
        add_row(48'd500, 5, 5, 5);
        add_row(48'd1000, -8388608, 8388607, -16777216, 1);
        add_row(48'd1000 + (48'd1 << 20), 100000, -50000, 3000000);
        add_row(48'd1000 + (48'd1 << 20) + (48'd1 << 36), 8388607, 8388607, -16777216);
        add_row(48'd1001 + (48'd1 << 20) + (48'd1 << 36), 0, 0, 0);
        add_row(48'd1001 + (48'd1 << 21) + (48'd1 << 36), -8388608, -8388608, 16777215);
        add_row(48'd1002 + (48'd1 << 21) + (48'd1 << 22) + (48'd1 << 36), 12345, -6789, -1);
        add_row(48'd1001 + (48'd1 << 21) + (48'd1 << 22) + (48'd1 << 36), 7, 7, 7);
        add_row(48'd1019 + (48'd1 << 22) + (48'd1 << 23) + (48'd1 << 36), -1, -1, -1);
        add_row(48'd1020 + (48'd1 << 22) + (48'd1 << 23) + (48'd1 << 36), 8388607, 0, 16777215);

        @(posedge rst_n);
        @(negedge clk);
        foreach (stim_table[i])
            send_sample(stim_table[i]);

        // Random stream: mostly rising stamps, some stale ones.
        cur = stim_table[stim_table.size() - 1].stamp;
        sent = 0;
        while (sent < N_RANDOM)
        begin
            quiet = (sent >= 600 && sent < 800);
            if (sent == 300 && !hold_req)
                hold_req = 1'b1;
            if (sent == 1000)
            begin
                in_valid <= 1'b0;
                wait (pending_poses.size() == 0 && !out_valid);
                @(negedge clk);
            end
            if (sent == 700 && !cur[47])
                cur = cur + (48'd1 << 47);
            pick = $urandom_range(99);
            ok = 1'b1;
            if (pick < 8 && cur > 0)
            begin
                r.stamp = cur - 48'($urandom_range(1, 5000));
                ok = 1'b0;
            end
            else
            begin
                if (pick < 50)
                    inc = 48'($urandom_range(0, 2000));
                else if (pick < 80)
                    inc = 48'($urandom_range(0, (1 << 24) + 100));
                else if (pick < 95)
                    inc = 48'($urandom_range(0, 1 << 30));
                else if (pick < 99)
                    inc = {8'd0, $urandom, 8'd0};
                else
                    inc = 48'({$urandom, $urandom}) & 48'h1FFF_FFFF_FFFF;
                if (cur > 48'hF000_0000_0000 - inc)
                    inc = '0;
                cur = cur + inc;
                r.stamp = cur;
            end
            if ($urandom_range(3) == 0)
            begin
                r.vf = VEL_W'($urandom_range(0, 2000) - 1000);
                r.vs = VEL_W'($urandom_range(0, 2000) - 1000);
                r.wr = RATE_W'($urandom_range(0, 2000) - 1000);
            end
            else
            begin
                r.vf = VEL_W'($urandom);
                r.vs = VEL_W'($urandom);
                r.wr = RATE_W'($urandom);
            end
            r.known = 1'b0;
            send_sample(r);
            if (ok)
                sent++;
        end
        quiet = 1'b0;

        // Largest stamp near the end, since every later stamp would be stale; a zero stamp follows.
        r.stamp = 48'hFFFF_FFFF_FFFF;
        r.vf = 24'h7FFFFF;
        r.vs = 24'h800000;
        r.wr = 25'h0FFFFFF;
        send_sample(r);
        r.stamp = 48'h0;
        send_sample(r);
        in_valid <= 1'b0;

        wait (pending_poses.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
